[design/modular_exponentiation_assert.svh]
// assertion macros shared by the modular exponentiation rtl
// every use assumes ports named clock and reset in the asserting module
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

`ifndef SYNTH
// checked outside reset
`define MODEXP_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("modexp assertion failed");
// checked during reset as well
`define MODEXP_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("modexp assertion failed");
`else
`define MODEXP_ASSERT(lbl, prop)
`define MODEXP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[design/modexp_pkg.sv]
// shared types and constants of the modular exponentiation block
// no dependencies
`timescale 1ns / 1ps

package modexp_pkg;

   localparam int EXP_BITS_DEF = 32;
   localparam int MOD_BITS_DEF = 31;
   localparam int BASE_W       = 31;
   localparam logic [31:0] MODULUS_RESET = 32'd998244353;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RED_GO,
      ST_RED_WAIT,
      ST_SQR_GO,
      ST_SQR_WAIT,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      OP_REDUCE,
      OP_SQUARE,
      OP_MULT
   } mm_op_type;

   typedef struct packed {
      logic      load;
      logic      mm_start;
      mm_op_type op;
      logic      take;
      logic      shift;
      logic      emit;
   } cmd_type;

   typedef struct packed {
      logic mm_done;
      logic exp_bit;
      logic last_bit;
      logic out_free;
      logic mod_small;
   } status_type;

endpackage

[design/modexp_mulmod.sv]
// bit-serial modular multiplier, one operand bit per cycle, msb first
// depends on modexp_pkg and modular_exponentiation_assert.svh
`timescale 1ns / 1ps
`include "modular_exponentiation_assert.svh"

module modexp_mulmod import modexp_pkg::*; #(
   parameter int MOD_BITS = MOD_BITS_DEF,
   parameter int OPA_W    = MOD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [OPA_W-1:0]    op_a,
   input  logic [MOD_BITS-1:0] op_b,
   input  logic [MOD_BITS-1:0] modulus,
   output logic                done,
   output logic [MOD_BITS-1:0] product
);

   localparam int CNT_W = $clog2(OPA_W + 1);
   localparam int ACC_W = MOD_BITS + 2;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff;
   logic [OPA_W-1:0]    a_ff;
   logic [MOD_BITS-1:0] b_ff;
   logic [MOD_BITS-1:0] acc_ff, acc_in;

   logic [ACC_W-1:0] addend, sum, mod1, mod2, reduced;
   logic             last_step;

   assign last_step = busy_ff && (cnt_ff == CNT_W'(1));

   // acc < m and b < m keep 2*acc + b below 3*m
   always_comb begin
      addend  = a_ff[OPA_W-1] ? ACC_W'(b_ff) : '0;
      sum     = {1'b0, acc_ff, 1'b0} + addend;
      mod1    = ACC_W'(modulus);
      mod2    = {1'b0, modulus, 1'b0};
      if (sum >= mod2) begin
         reduced = sum - mod2;
      end else if (sum >= mod1) begin
         reduced = sum - mod1;
      end else begin
         reduced = sum;
      end
      acc_in = reduced[MOD_BITS-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      if (start) begin
         busy_in = 1'b1;
      end else if (last_step) begin
         busy_in = 1'b0;
      end
      done_in = last_step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= op_a;
         b_ff   <= op_b;
         acc_ff <= '0;
         cnt_ff <= CNT_W'(OPA_W);
      end else if (busy_ff) begin
         a_ff   <= {a_ff[OPA_W-2:0], 1'b0};
         acc_ff <= acc_in;
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

   `MODEXP_ASSERT(a_start_when_free, start |-> !busy_ff)
   `MODEXP_ASSERT(a_done_after_busy, done_ff |-> $past(busy_ff) && !busy_ff)

endmodule

[design/modexp_datapath.sv]
// datapath: modulus register, operands, exponent scan, result register
// depends on modexp_pkg, modexp_mulmod and modular_exponentiation_assert.svh
`timescale 1ns / 1ps
`include "modular_exponentiation_assert.svh"

module modexp_datapath import modexp_pkg::*; #(
   parameter int EXP_BITS = EXP_BITS_DEF,
   parameter int MOD_BITS = MOD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [MOD_BITS-1:0] csr_wr_data,
   input  logic [BASE_W-1:0]   in_base,
   input  logic [EXP_BITS-1:0] in_exponent,
   input  cmd_type             cmd,
   output status_type          status,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [MOD_BITS-1:0] out_result
);

   localparam int OPA_W  = (BASE_W > MOD_BITS) ? BASE_W : MOD_BITS;
   localparam int ECNT_W = $clog2(EXP_BITS + 1);

   logic [MOD_BITS-1:0] modulus_ff;
   logic [BASE_W-1:0]   base_ff;
   logic [MOD_BITS-1:0] bred_ff;
   logic [MOD_BITS-1:0] r_ff;
   logic [EXP_BITS-1:0] exp_ff;
   logic [ECNT_W-1:0]   exp_cnt_ff;
   logic [MOD_BITS-1:0] out_ff;
   logic                out_valid_ff, out_valid_in;

   logic [OPA_W-1:0]    mm_a;
   logic [MOD_BITS-1:0] mm_b;
   logic [MOD_BITS-1:0] mm_product;
   logic                mm_done;

   always_comb begin
      case (cmd.op)
         OP_REDUCE: begin
            // base mod m as base * 1
            mm_a = OPA_W'(base_ff);
            mm_b = MOD_BITS'(1);
         end
         OP_MULT: begin
            mm_a = OPA_W'(r_ff);
            mm_b = bred_ff;
         end
         default: begin
            mm_a = OPA_W'(r_ff);
            mm_b = r_ff;
         end
      endcase
   end

   modexp_mulmod #(
      .MOD_BITS (MOD_BITS),
      .OPA_W    (OPA_W)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mm_start),
      .op_a    (mm_a),
      .op_b    (mm_b),
      .modulus (modulus_ff),
      .done    (mm_done),
      .product (mm_product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MOD_BITS'(MODULUS_RESET);
      end else if (csr_wr_en) begin
         modulus_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff    <= in_base;
         exp_ff     <= in_exponent;
         exp_cnt_ff <= ECNT_W'(EXP_BITS);
         r_ff       <= MOD_BITS'(1);
      end else begin
         if (cmd.take) begin
            if (cmd.op == OP_REDUCE) begin
               bred_ff <= mm_product;
            end else begin
               r_ff <= mm_product;
            end
         end
         if (cmd.shift) begin
            exp_ff     <= exp_ff << 1;
            exp_cnt_ff <= exp_cnt_ff - ECNT_W'(1);
         end
      end
   end

   // output register frees the engine while the receiver stalls
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_ff <= status.mod_small ? '0 : r_ff;
      end
   end

   always_comb begin
      status.mm_done   = mm_done;
      status.exp_bit   = exp_ff[EXP_BITS-1];
      status.last_bit  = (exp_cnt_ff == ECNT_W'(1));
      status.out_free  = !out_valid_ff || out_ready;
      status.mod_small = (modulus_ff < MOD_BITS'(2));
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

   `MODEXP_ASSERT(a_shift_in_range, cmd.shift |-> exp_cnt_ff != '0)

endmodule

[design/modexp_ctrl.sv]
// controller: sequences reduction, squares and multiplies over the exponent
// depends on modexp_pkg and modular_exponentiation_assert.svh
`timescale 1ns / 1ps
`include "modular_exponentiation_assert.svh"

module modexp_ctrl import modexp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               state_in = status.mod_small ? ST_FINISH : ST_RED_GO;
            end
         end
         ST_RED_GO:   state_in = ST_RED_WAIT;
         ST_RED_WAIT: begin
            if (status.mm_done) begin
               state_in = ST_SQR_GO;
            end
         end
         ST_SQR_GO:   state_in = ST_SQR_WAIT;
         ST_SQR_WAIT: begin
            if (status.mm_done) begin
               if (status.exp_bit) begin
                  state_in = ST_MUL_GO;
               end else begin
                  state_in = status.last_bit ? ST_FINISH : ST_SQR_GO;
               end
            end
         end
         ST_MUL_GO:   state_in = ST_MUL_WAIT;
         ST_MUL_WAIT: begin
            if (status.mm_done) begin
               state_in = status.last_bit ? ST_FINISH : ST_SQR_GO;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd      = '0;
      cmd.op   = OP_SQUARE;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_valid;
         end
         ST_RED_GO: begin
            cmd.op       = OP_REDUCE;
            cmd.mm_start = 1'b1;
         end
         ST_RED_WAIT: begin
            cmd.op   = OP_REDUCE;
            cmd.take = status.mm_done;
         end
         ST_SQR_GO: begin
            cmd.mm_start = 1'b1;
         end
         ST_SQR_WAIT: begin
            cmd.take  = status.mm_done;
            cmd.shift = status.mm_done && !status.exp_bit;
         end
         ST_MUL_GO: begin
            cmd.op       = OP_MULT;
            cmd.mm_start = 1'b1;
         end
         ST_MUL_WAIT: begin
            cmd.op    = OP_MULT;
            cmd.take  = status.mm_done;
            cmd.shift = status.mm_done;
         end
         ST_FINISH: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // the multiplier only reports while the controller waits for it
   `MODEXP_ASSERT(a_done_in_wait, status.mm_done |-> (state_ff == ST_RED_WAIT ||
      state_ff == ST_SQR_WAIT || state_ff == ST_MUL_WAIT))

endmodule

[design/modular_exponentiation.sv]
// Modular exponentiation: power_result = base_value ** exponent mod modulus.
// Input channel req_*: one transfer carries base_value and exponent.
// Result channel rsp_*: one transfer per input carries power_result.
// csr_wr_en / csr_wr_data write the modulus; write only while the block is idle.
// The exponent is scanned msb first: a modular square per bit, plus a modular
// multiply by the base for each set bit. A shared bit-serial multiplier does
// each product over OPA_W = max(31, MOD_BITS) operand bits, and the base is
// first reduced by one pass of the same unit. A modulus of 0 or 1 answers 0
// without running the multiplier. One item is worked on at a time.
// req_tready is high only while the engine is idle. The result sits in an
// output register, so the next item may be accepted while rsp_tvalid waits
// for rsp_tready; the engine holds a finished result until that register frees.
// Reset (synchronous, active high) drops any item in flight, clears rsp_tvalid
// and loads the modulus with 998244353.
// depends on modexp_pkg, modexp_ctrl and modexp_datapath
`timescale 1ns / 1ps

module modular_exponentiation import modexp_pkg::*; #(
   parameter int EXP_BITS = EXP_BITS_DEF,
   parameter int MOD_BITS = MOD_BITS_DEF,
   localparam int REQ_W   = ((BASE_W + EXP_BITS + 7) / 8) * 8,
   localparam int RSP_W   = ((MOD_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [MOD_BITS-1:0] csr_wr_data,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_W-1:0]    req_tdata,   // base_value, exponent, zero fill
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata    // power_result, zero fill
);

   cmd_type             cmd;
   status_type          status;
   logic [MOD_BITS-1:0] result;

   modexp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   modexp_datapath #(
      .EXP_BITS (EXP_BITS),
      .MOD_BITS (MOD_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_base     (req_tdata[BASE_W-1:0]),
      .in_exponent (req_tdata[BASE_W +: EXP_BITS]),
      .cmd         (cmd),
      .status      (status),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (result)
   );

   assign rsp_tdata = RSP_W'(result);

endmodule

[bench/modular_exponentiation_tb.sv]
// testbench for modular_exponentiation: base ** exponent mod modulus over a stream interface
// drives req_/rsp_/csr_ ports, predicts each power with its own square-and-multiply loop
// depends on modexp_pkg and the modular_exponentiation rtl
`timescale 1ns / 1ps

module modular_exponentiation_tb;
   import modexp_pkg::*;

   localparam int EXP_BITS = EXP_BITS_DEF;
   localparam int MOD_BITS = MOD_BITS_DEF;
   localparam int REQ_W    = ((BASE_W + EXP_BITS + 7) / 8) * 8;
   localparam int RSP_W    = ((MOD_BITS + 7) / 8) * 8;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 9;
   localparam int HOLD_CYCLES    = 8000;   // long receiver back-pressure
   localparam int TAIL_CYCLES    = 2400;   // a bit over the worst item latency
   localparam int WATCHDOG_LIMIT = 40000;

   // expected powers, in order of accepted requests
   class power_scoreboard;
      logic [MOD_BITS-1:0] modulus;
      logic [MOD_BITS-1:0] expected_q[$];
      int                  requests;
      int                  results;
      int                  mismatches;

      function new();
         modulus    = MODULUS_RESET[MOD_BITS-1:0];
         requests   = 0;
         results    = 0;
         mismatches = 0;
      endfunction

      function logic [MOD_BITS-1:0] power_mod(logic [BASE_W-1:0] b, logic [EXP_BITS-1:0] e);
         longint unsigned m;
         longint unsigned bb;
         longint unsigned acc;
         if (modulus == 0) return '0;
         m   = modulus;
         bb  = b % m;
         acc = 1 % m;
         for (int i = EXP_BITS - 1; i >= 0; i--) begin
            acc = (acc * acc) % m;
            if (e[i]) acc = (acc * bb) % m;
         end
         return acc[MOD_BITS-1:0];
      endfunction

      function void note_request(logic [REQ_W-1:0] tdata);
         expected_q.push_back(power_mod(tdata[BASE_W-1:0], tdata[BASE_W +: EXP_BITS]));
         requests++;
      endfunction

      function void check_result(logic [RSP_W-1:0] tdata);
         logic [MOD_BITS-1:0] want;
         results++;
         if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: result with none expected: expected none, actual %0d",
                     $time, tdata[MOD_BITS-1:0]);
            return;
         end
         want = expected_q.pop_front();
         if (tdata[MOD_BITS-1:0] !== want) begin
            mismatches++;
            $display("%0t: power_result mismatch: expected %0d, actual %0d",
                     $time, want, tdata[MOD_BITS-1:0]);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [MOD_BITS-1:0] csr_wr_data;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata;   // base_value, exponent, zero fill
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_W-1:0]    rsp_tdata;   // power_result, zero fill

   power_scoreboard sb;
   bit              steady;
   bit              hold_pending;
   int              idle_cycles;
   int              settings;

   modular_exponentiation u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   // response check comes first: a result never belongs to a request of the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_request(req_tdata);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, sb.pending());
      $display("[FAIL] regression broken");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_pending) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_pending = 1'b0;
         end else begin
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
               rsp_tready = 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_tready = 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_request(input logic [BASE_W-1:0] b, input logic [EXP_BITS-1:0] e);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = '0;
      req_tdata[BASE_W-1:0]         = b;
      req_tdata[BASE_W +: EXP_BITS] = e;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (sb.pending() > 0) @(negedge clock);
   endtask

   task automatic write_modulus(input logic [MOD_BITS-1:0] value);
      csr_wr_data = value;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      sb.modulus  = value;
      settings++;
   endtask

   function automatic logic [BASE_W-1:0] pick_base(logic [MOD_BITS-1:0] m);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 1;
         2: return m - 1;
         3: return m;
         4: return BASE_W'($urandom_range(0, 15));
         5: return '1;
         6: return (m == 0) ? BASE_W'($urandom) : BASE_W'($urandom % m);
         default: return BASE_W'($urandom);
      endcase
   endfunction

   function automatic logic [EXP_BITS-1:0] pick_exponent(logic [MOD_BITS-1:0] m);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 1;
         2: return '1;
         3: return EXP_BITS'($urandom_range(0, 63));
         4: return EXP_BITS'(1) << $urandom_range(0, EXP_BITS - 1);
         5: return EXP_BITS'(m) - 1;
         default: return EXP_BITS'($urandom);
      endcase
   endfunction

   task automatic random_items(input int count);
      repeat (count) send_request(pick_base(sb.modulus), pick_exponent(sb.modulus));
   endtask

   task automatic run_setting(input logic [MOD_BITS-1:0] m, input int count, input bit calm);
      write_modulus(m);
      steady = calm;
      random_items(count);
      wait_drained();
   endtask

   initial begin
      sb           = new();
      steady       = 1'b0;
      hold_pending = 1'b0;
      idle_cycles  = 0;
      settings     = 1;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // reset modulus: field extremes and the named corner cases
      hold_pending = 1'b1;
      send_request(0, 0);
      send_request(0, 5);
      send_request(1, '1);
      send_request('1, '1);
      send_request('1, 0);
      send_request(2, 1);
      send_request(2, 31);
      send_request(31'd998244352, 2);
      send_request(31'd998244353, 7);            // base equal to the modulus
      send_request(31'd998244354, 3);            // base above the modulus
      send_request(3, 32'h8000_0000);
      send_request(5, 1);
      send_request(12345, 32'd998244352);        // fermat: gives 1
      send_request(31'h5555_5555, 32'hAAAA_AAAA);
      send_request(31'h2AAA_AAAA, 32'h5555_5555);
      send_request(7, 32'h0000_FFFF);
      send_request(31'h4000_0000, 32'hFFFF_0000);
      send_request(10, 2);
      random_items(100);
      wait_drained();

      run_setting(31'h7FFF_FFFF, 100, 1'b0);
      run_setting(1, 40, 1'b0);                  // modulus of one
      run_setting(0, 40, 1'b0);                  // zero modulus, out of range
      run_setting(2, 60, 1'b0);
      run_setting(3, 60, 1'b1);
      run_setting(31'd1000000007, 100, 1'b1);
      run_setting(31'd65537, 80, 1'b0);
      run_setting(MOD_BITS'($urandom_range(2, 32'h7FFF_FFFF)), 100, 1'b0);
      run_setting(MOD_BITS'($urandom_range(2, 1000)), 100, 1'b0);

      steady = 1'b0;
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("%0d requests and %0d results over %0d modulus settings,", sb.requests,
               sb.results, settings);
      $display("including moduli 0, 1, 2, 2^31-1 and a long result hold-off");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
